[rtl/gped_pkg.sv]
`timescale 1ns / 1ps
// gped_pkg: shared types, register map and opcodes for the gpio port
// no dependencies; used by every module of the block

package gped_pkg;

  localparam int NUM_PINS      = 32;
  localparam int PINS_PER_WORD = 10;
  localparam int FSEL_BITS     = 3;
  localparam int FSEL_WORDS    = 4;

  localparam logic [31:0] PIN_MASK = 32'((33'd1 << NUM_PINS) - 33'd1);

  localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

  // transaction opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register word indexes
  localparam logic [3:0] REG_FSEL0   = 4'd0;
  localparam logic [3:0] REG_FSEL1   = 4'd1;
  localparam logic [3:0] REG_FSEL2   = 4'd2;
  localparam logic [3:0] REG_FSEL3   = 4'd3;
  localparam logic [3:0] REG_OUT_SET = 4'd4;
  localparam logic [3:0] REG_OUT_CLR = 4'd5;
  localparam logic [3:0] REG_LEVEL   = 4'd6;
  localparam logic [3:0] REG_EVENT   = 4'd7;
  localparam logic [3:0] REG_RISE_EN = 4'd8;
  localparam logic [3:0] REG_FALL_EN = 4'd9;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } gped_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pin_out;
    logic [31:0] pin_drive;
    logic        irq_pending;
  } gped_out_t;

endpackage

[rtl/gpio_port_with_edge_detect.sv]
`timescale 1ns / 1ps
// gpio_port_with_edge_detect: top level of the 32-pin gpio port
// depends on gped_pkg, gped_in_stage, gped_regs, gped_out_stage

// Each input transaction is a bus read, a bus write or a pin sample tick, and
// each gives exactly one result transaction that shows the port state after it:
// read data (zero unless a read), output latch, drive mask (pins whose function
// code is 1) and the event interrupt. Transactions are taken one per cycle while
// the output does not stall. An accepted transaction is held in the input
// register; its result is written to the result register once that register
// is free, and out_valid then rises. The state update and the result decode
// are one short pass of logic between those two registers. When the output
// stalls, the result register holds one result and the input register one
// more transaction, and then in_ready drops.
module gpio_port_with_edge_detect (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gped_pkg::gped_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gped_pkg::gped_out_t out_data
);

  logic                item_valid;
  gped_pkg::gped_in_t  item;
  gped_pkg::gped_out_t result;
  logic                free;
  logic                step;

  // a held item is processed when the result register can take its result
  assign step = item_valid && free;

  gped_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // register state and decode; state moves only on step
  gped_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  gped_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // every processed transaction lands in the result register
  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed transaction did not produce a result");

  // only reads return data
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    step && (item.opcode != gped_pkg::OP_READ) |=> (out_data.read_data == '0))
    else $error("non-read transaction returned read data");

  // no output bits for pins that do not exist
  a_pin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.pin_out & ~gped_pkg::PIN_MASK) == '0)
               && ((out_data.pin_drive & ~gped_pkg::PIN_MASK) == '0))
    else $error("output bits set beyond the pin count");

  // reset empties both stages
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !item_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

[rtl/gped_in_stage.sv]
`timescale 1ns / 1ps
// gped_in_stage: input register for incoming transactions
// depends on gped_pkg

module gped_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gped_pkg::gped_in_t in_data,
  input  logic               advance,
  output logic               item_valid,
  output gped_pkg::gped_in_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

[rtl/gped_regs.sv]
`timescale 1ns / 1ps
// gped_regs: gpio register state, bus decode and edge detection
// depends on gped_pkg

module gped_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  gped_pkg::gped_in_t  item,
  output gped_pkg::gped_out_t result
);

  logic [gped_pkg::FSEL_BITS-1:0] fsel      [gped_pkg::NUM_PINS];
  logic [gped_pkg::FSEL_BITS-1:0] fsel_next [gped_pkg::NUM_PINS];
  logic [31:0] output_latch, output_latch_next;
  logic [31:0] rising_enable, rising_enable_next;
  logic [31:0] falling_enable, falling_enable_next;
  logic [31:0] event_status, event_status_next;
  logic [31:0] last_levels, last_levels_next;

  logic [31:0] fsel_word [gped_pkg::FSEL_WORDS];
  logic [31:0] levels;
  logic [31:0] edge_events;
  logic [31:0] rdata;
  logic [31:0] drive;
  logic        is_write;
  logic        fsel_hit;

  // packed view of the function select words
  always_comb begin
    for (int w = 0; w < gped_pkg::FSEL_WORDS; w++) begin
      fsel_word[w] = '0;
    end
    for (int p = 0; p < gped_pkg::NUM_PINS; p++) begin
      fsel_word[p / gped_pkg::PINS_PER_WORD]
        [(p % gped_pkg::PINS_PER_WORD) * gped_pkg::FSEL_BITS +: gped_pkg::FSEL_BITS] = fsel[p];
    end
  end

  assign levels      = item.pin_levels & gped_pkg::PIN_MASK;
  assign edge_events = (levels & ~last_levels & rising_enable)
                     | (~levels & last_levels & falling_enable);
  assign is_write    = (item.opcode == gped_pkg::OP_WRITE);
  assign fsel_hit    = is_write && (item.reg_index <= gped_pkg::REG_FSEL3);

  always_comb begin
    output_latch_next   = output_latch;
    rising_enable_next  = rising_enable;
    falling_enable_next = falling_enable;
    event_status_next   = event_status;
    last_levels_next    = last_levels;
    rdata               = '0;

    case (item.opcode)
      gped_pkg::OP_READ: begin
        case (item.reg_index)
          gped_pkg::REG_FSEL0, gped_pkg::REG_FSEL1,
          gped_pkg::REG_FSEL2, gped_pkg::REG_FSEL3: rdata = fsel_word[item.reg_index[1:0]];
          gped_pkg::REG_LEVEL:   rdata = last_levels;
          gped_pkg::REG_EVENT:   rdata = event_status;
          gped_pkg::REG_RISE_EN: rdata = rising_enable;
          gped_pkg::REG_FALL_EN: rdata = falling_enable;
          default:               rdata = '0;
        endcase
      end
      gped_pkg::OP_WRITE: begin
        case (item.reg_index)
          gped_pkg::REG_OUT_SET:
            output_latch_next = output_latch | (item.write_data & gped_pkg::PIN_MASK);
          gped_pkg::REG_OUT_CLR: output_latch_next = output_latch & ~item.write_data;
          gped_pkg::REG_EVENT:   event_status_next = event_status & ~item.write_data;
          gped_pkg::REG_RISE_EN: rising_enable_next = item.write_data & gped_pkg::PIN_MASK;
          gped_pkg::REG_FALL_EN: falling_enable_next = item.write_data & gped_pkg::PIN_MASK;
          default: ;
        endcase
      end
      gped_pkg::OP_TICK: begin
        event_status_next = event_status | edge_events;
        last_levels_next  = levels;
      end
      default: ;
    endcase
  end

  // function select write: each pin takes its field from its own word
  always_comb begin
    for (int p = 0; p < gped_pkg::NUM_PINS; p++) begin
      if (fsel_hit && (32'(item.reg_index) == 32'(p / gped_pkg::PINS_PER_WORD))) begin
        fsel_next[p] = item.write_data
          [(p % gped_pkg::PINS_PER_WORD) * gped_pkg::FSEL_BITS +: gped_pkg::FSEL_BITS];
      end else begin
        fsel_next[p] = fsel[p];
      end
    end
  end

  always_comb begin
    drive = '0;
    for (int p = 0; p < gped_pkg::NUM_PINS; p++) begin
      drive[p] = (fsel_next[p] == gped_pkg::FSEL_OUTPUT);
    end
  end

  assign result.read_data   = rdata;
  assign result.pin_out     = output_latch_next;
  assign result.pin_drive   = drive;
  assign result.irq_pending = |event_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < gped_pkg::NUM_PINS; p++) begin
        fsel[p] <= '0;
      end
      output_latch   <= '0;
      rising_enable  <= '0;
      falling_enable <= '0;
      event_status   <= '0;
      last_levels    <= '0;
    end else if (step) begin
      for (int p = 0; p < gped_pkg::NUM_PINS; p++) begin
        fsel[p] <= fsel_next[p];
      end
      output_latch   <= output_latch_next;
      rising_enable  <= rising_enable_next;
      falling_enable <= falling_enable_next;
      event_status   <= event_status_next;
      last_levels    <= last_levels_next;
    end
  end

endmodule

[rtl/gped_out_stage.sv]
`timescale 1ns / 1ps
// gped_out_stage: result register holding one finished transaction
// depends on gped_pkg

module gped_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  gped_pkg::gped_out_t result,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output gped_pkg::gped_out_t out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule
